[rtl/serial_pointer_command_parser_defines.svh]
// Assertion macros for the serial pointer command parser.
`ifndef SERIAL_POINTER_COMMAND_PARSER_DEFINES_SVH
`define SERIAL_POINTER_COMMAND_PARSER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SPCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spcp assertion failed");

// Next-cycle implication.
`define SPCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spcp assertion failed");

`else

`define SPCP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPCP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/spcp_pkg.sv]
// Package: constants, types and match helpers for the pointer command parser.
`default_nettype none

package spcp_pkg;

    localparam int unsigned KW_NUM = 5;

    // keyword flag positions
    localparam int unsigned KW_UP    = 0;
    localparam int unsigned KW_DOWN  = 1;
    localparam int unsigned KW_LEFT  = 2;
    localparam int unsigned KW_RIGHT = 3;
    localparam int unsigned KW_MV    = 4;

    typedef logic [KW_NUM-1:0] t_alive;

    localparam t_alive     ALIVE_ALL  = '1;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [6:0] STEP_RESET = 7'd5;
    localparam logic [2:0] POS_MAX    = 3'd7;

    localparam logic [2:0] LEN_UP     = 3'd2;
    localparam logic [2:0] LEN_DOWN   = 3'd4;
    localparam logic [2:0] LEN_LEFT   = 3'd4;
    localparam logic [2:0] LEN_RIGHT  = 3'd5;
    localparam logic [2:0] LEN_MV     = 3'd3;

    // hex field byte positions
    localparam logic [2:0] POS_X_HI   = 3'd3;
    localparam logic [2:0] POS_X_LO   = 3'd4;
    localparam logic [2:0] POS_Y_HI   = 3'd5;
    localparam logic [2:0] POS_Y_LO   = 3'd6;

    typedef struct packed {
        logic       valid;
        logic [3:0] digit;
    } t_hex;

    // Per-keyword "byte matches at this position" mask. The MV: flag is only
    // tested on its three prefix bytes; later bytes never clear it.
    function automatic t_alive kw_ok(input logic [7:0] c, input logic [2:0] p);
        t_alive ok;
        unique case (p)
            3'd0:    ok = {c == "M", c == "R", c == "L", c == "D", c == "U"};
            3'd1:    ok = {c == "V", c == "I", c == "E", c == "O", c == "P"};
            3'd2:    ok = {c == ":", c == "G", c == "F", c == "W", 1'b0};
            3'd3:    ok = {1'b1, c == "H", c == "T", c == "N", 1'b0};
            3'd4:    ok = {1'b1, c == "T", 1'b0, 1'b0, 1'b0};
            default: ok = {1'b1, 4'b0000};
        endcase
        return ok;
    endfunction

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.digit = 4'd0;
        if (c >= "0" && c <= "9") begin
            h.digit = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            h.digit = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            h.digit = 4'(c - "A" + 8'd10);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

[rtl/serial_pointer_command_parser.sv]
// Top level: line parser that turns received bytes into relative pointer moves.
`default_nettype none

// Serial pointer command parser. Bytes arrive one per slave transaction;
// 0x0A ends a line and produces exactly one master transaction, every other
// byte produces none. The lines UP, DOWN, LEFT and RIGHT move by the
// configured step (-y, +y, -x, +x); a line starting with "MV:" carries up to
// two hex digits of x at bytes 3-4 and of y at bytes 5-6, taken as 8-bit
// two's complement. Anything else gives match_kind 0 with zero moves.
// Rate: one byte per clock, sustained. A byte is held in the input register,
// then the parse state and, on a line end, the result register are updated
// from it; a result reaches the master port via the input and result registers.
// The only stall is a newline that finds the result register still full:
// the input register then holds until the master transaction completes.
// step_size resets to 5 and is written through i_cfg_we / i_cfg_wdata; the
// user must do so only while the block is idle, which it does not enforce.
module serial_pointer_command_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_wdata,   // step_size
    // byte stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    // move results out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [7:0] move_dx, [15:8] move_dy
    output logic             m_axis_tuser   // match_kind
);
    import spcp_pkg::*;

`include "serial_pointer_command_parser_defines.svh"

    // configuration
    logic [6:0]  r_step;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // line parse state
    logic [2:0]  r_line_pos, n_line_pos;
    t_alive      r_alive,    n_alive;
    logic [7:0]  r_hex_x,    n_hex_x;
    logic [7:0]  r_hex_y,    n_hex_y;
    logic [1:0]  r_stop,     n_stop;

    // result register
    logic        r_out_valid;
    logic        r_kind,     n_kind;
    logic [7:0]  r_dx,       n_dx;
    logic [7:0]  r_dy,       n_dy;

    logic        w_is_lf;
    logic        w_advance;
    logic [7:0]  w_step8;
    logic [7:0]  w_step_neg;
    t_hex        w_hex;
    logic        w_field_y;
    logic        w_first;

    assign w_is_lf   = (r_in_byte == CHAR_LF);
    // a newline may only move on when the result register is free or draining
    assign w_advance = r_in_valid && (!w_is_lf || !r_out_valid || m_axis_tready);

    assign s_axis_tready = !r_in_valid || w_advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tdata  = {r_dy, r_dx};

    assign w_step8    = {1'b0, r_step};
    assign w_step_neg = 8'd0 - w_step8;
    assign w_hex      = hex_decode(r_in_byte);
    assign w_field_y  = (r_line_pos == POS_Y_HI) || (r_line_pos == POS_Y_LO);
    assign w_first    = (r_line_pos == POS_X_HI) || (r_line_pos == POS_Y_HI);

    // parse step for the byte in the input register
    always_comb begin
        n_line_pos = r_line_pos;
        n_alive    = r_alive;
        n_hex_x    = r_hex_x;
        n_hex_y    = r_hex_y;
        n_stop     = r_stop;
        n_kind     = 1'b0;
        n_dx       = 8'd0;
        n_dy       = 8'd0;

        if (w_is_lf) begin
            // keywords checked in fixed priority, MV: last
            if (r_alive[KW_UP] && r_line_pos == LEN_UP) begin
                n_kind = 1'b1;
                n_dy   = w_step_neg;
            end else if (r_alive[KW_DOWN] && r_line_pos == LEN_DOWN) begin
                n_kind = 1'b1;
                n_dy   = w_step8;
            end else if (r_alive[KW_LEFT] && r_line_pos == LEN_LEFT) begin
                n_kind = 1'b1;
                n_dx   = w_step_neg;
            end else if (r_alive[KW_RIGHT] && r_line_pos == LEN_RIGHT) begin
                n_kind = 1'b1;
                n_dx   = w_step8;
            end else if (r_alive[KW_MV] && r_line_pos >= LEN_MV) begin
                n_kind = 1'b1;
                n_dx   = r_hex_x;
                n_dy   = r_hex_y;
            end
            n_line_pos = 3'd0;
            n_alive    = ALIVE_ALL;
            n_hex_x    = 8'd0;
            n_hex_y    = 8'd0;
            n_stop     = 2'b00;
        end else if (r_line_pos != POS_MAX) begin
            n_alive    = r_alive & kw_ok(r_in_byte, r_line_pos);
            n_line_pos = r_line_pos + 3'd1;
            // hex fields: a non-hex byte freezes its field
            if (r_line_pos >= POS_X_HI && !r_stop[w_field_y]) begin
                if (!w_hex.valid) begin
                    n_stop[w_field_y] = 1'b1;
                end else if (w_field_y) begin
                    n_hex_y = w_first ? {4'd0, w_hex.digit} : {r_hex_y[3:0], w_hex.digit};
                end else begin
                    n_hex_x = w_first ? {4'd0, w_hex.digit} : {r_hex_x[3:0], w_hex.digit};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RESET;
            r_in_valid  <= 1'b0;
            r_line_pos  <= 3'd0;
            r_alive     <= ALIVE_ALL;
            r_hex_x     <= 8'd0;
            r_hex_y     <= 8'd0;
            r_stop      <= 2'b00;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end

            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end

            if (w_advance) begin
                r_line_pos <= n_line_pos;
                r_alive    <= n_alive;
                r_hex_x    <= n_hex_x;
                r_hex_y    <= n_hex_y;
                r_stop     <= n_stop;
            end

            if (w_advance && w_is_lf) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_advance && w_is_lf) begin
            r_kind <= n_kind;
            r_dx   <= n_dx;
            r_dy   <= n_dy;
        end
    end

    // a no-match result carries zero moves
    `SPCP_ASSERT_IMP(a_nomatch_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 16'd0)
    // a processed newline always loads a result
    `SPCP_ASSERT_NXT(a_lf_result, i_clk, i_rst_n, w_advance && w_is_lf, r_out_valid)
    // a processed newline clears the line state
    `SPCP_ASSERT_NXT(a_lf_clear, i_clk, i_rst_n, w_advance && w_is_lf,
        r_line_pos == 3'd0 && r_alive == ALIVE_ALL && r_stop == 2'b00)
    // ordinary bytes never create a result
    `SPCP_ASSERT_NXT(a_no_spurious, i_clk, i_rst_n,
        !r_out_valid && !(w_advance && w_is_lf), !r_out_valid)
    // the x field stop flag only sets once the hex bytes are reached
    `SPCP_ASSERT_IMP(a_stop_pos, i_clk, i_rst_n,
        r_stop[0], r_line_pos >= POS_X_LO)

endmodule

`default_nettype wire
